FILE: rtl/assert_macros.svh
// assertion macros for the rtl files, included by rectangle_sum_query_engine.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/rsq_pkg.sv
// package for the rectangle sum query engine: constants, codes and types
`timescale 1ns / 1ps

package rsq_pkg;

  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 256;

  localparam int COORD_W = 9;
  localparam int DATA_W  = 32;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

  // opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [COORD_W-1:0] GRID_RESET = 9'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } rsq_state_t;

endpackage

FILE: rtl/rsq_cell_mem.sv
// single-port-write, single-port-read synchronous cell memory
`timescale 1ns / 1ps

module rsq_cell_mem
  import rsq_pkg::*;
#(
  parameter int DEPTH  = MAX_ROWS_DEF * MAX_COLS_DEF,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/rectangle_sum_query_engine.sv
// top level of the rectangle sum query engine
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The cells live in one synchronous memory of MAX_ROWS * MAX_COLS words, row-major,
// with one read and one write port. A load writes the cell in the accept cycle (a load
// outside the grid in use is dropped). A query walks its rectangle one cell per cycle
// through the single read port; a bad query (inverted corners, a zero coordinate or a
// corner beyond the grid) answers sum 0 with bad_query set. One transaction is in
// progress at a time; a finished result sits in an output register, so the next
// transaction is accepted while the result still waits to be taken. The grid size in
// use, nrows and ncols, saturates grid_rows and grid_cols at MAX_ROWS and MAX_COLS;
// resizing keeps the stored cells. The memory has no clearing pass: a query that
// covers a cell never loaded reads an undefined value.
module rectangle_sum_query_engine
  import rsq_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic [COORD_W-1:0]        row_top,
  input  logic [COORD_W-1:0]        col_left,
  input  logic [COORD_W-1:0]        row_bottom,
  input  logic [COORD_W-1:0]        col_right,
  input  logic signed [DATA_W-1:0]  value,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DATA_W-1:0]  sum,
  output logic                      bad_query
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  logic [COORD_W-1:0] grid_rows;
  logic [COORD_W-1:0] grid_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= GRID_RESET;
      grid_cols <= GRID_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GRID_ROWS: grid_rows <= cfg_data;
        CFG_GRID_COLS: grid_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // grid size in use, saturated to the memory shape
  logic [COORD_W-1:0] nrows;
  logic [COORD_W-1:0] ncols;

  assign nrows = (32'(grid_rows) > MAX_ROWS) ? COORD_W'(MAX_ROWS) : grid_rows;
  assign ncols = (32'(grid_cols) > MAX_COLS) ? COORD_W'(MAX_COLS) : grid_cols;

  rsq_state_t state;
  rsq_state_t state_next;

  logic in_fire;
  logic is_query;
  logic query_bad;
  logic load_ok;
  logic out_free;
  logic last_issue;

  // walk registers, 0-based
  logic [COORD_W-1:0] row_cnt;
  logic [COORD_W-1:0] row_end;
  logic [COORD_W-1:0] col_cnt;
  logic [COORD_W-1:0] col_start;
  logic [COORD_W-1:0] col_end;
  logic [ADDR_W-1:0]  row_base;
  logic [DATA_W-1:0]  acc;
  logic               bad;
  logic               rd_valid;

  // first-row base and load address from the top-left corner
  logic [COORD_W-1:0] top_idx;
  logic [COORD_W-1:0] left_idx;
  logic [ADDR_W-1:0]  top_base;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign is_query = (op == OP_QUERY);
  assign out_free = !out_valid || out_ready;

  assign top_idx  = row_top - COORD_W'(1);
  assign left_idx = col_left - COORD_W'(1);
  assign top_base = ADDR_W'(top_idx) * ADDR_W'(MAX_COLS);

  assign query_bad = (row_top == '0) || (col_left == '0) ||
                     (row_top > row_bottom) || (col_left > col_right) ||
                     (row_bottom > nrows) || (col_right > ncols);

  assign load_ok = (row_top != '0) && (row_top <= nrows) &&
                   (col_left != '0) && (col_left <= ncols);

  // cell writes happen in the accept cycle of a load
  assign mem_we    = in_fire && !is_query && load_ok;
  assign mem_waddr = top_base + ADDR_W'(left_idx);
  assign mem_raddr = row_base + ADDR_W'(col_cnt);

  assign last_issue = (state == ST_READ) && (col_cnt == col_end) && (row_cnt == row_end);

  rsq_cell_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_cell_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (value),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && is_query) begin
          state_next = query_bad ? ST_FINISH : ST_READ;
        end
      end
      ST_READ: begin
        if (last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // read-data valid marks the cycle after a read is issued, when its registered data arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_READ);
    end
  end

  // walk counters and accumulator
  always_ff @(posedge clk) begin
    if (in_fire && is_query) begin
      bad       <= query_bad;
      row_cnt   <= top_idx;
      row_end   <= row_bottom - COORD_W'(1);
      col_cnt   <= left_idx;
      col_start <= left_idx;
      col_end   <= col_right - COORD_W'(1);
      row_base  <= top_base;
    end else if (state == ST_READ) begin
      if (col_cnt == col_end) begin
        col_cnt  <= col_start;
        row_cnt  <= row_cnt + COORD_W'(1);
        row_base <= row_base + ADDR_W'(MAX_COLS);
      end else begin
        col_cnt <= col_cnt + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_query) begin
      acc <= '0;
    end else if (rd_valid) begin
      acc <= acc + mem_rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      sum       <= acc;
      bad_query <= bad;
    end
  end

  // read data only arrives while a walk is in progress
  `ASSERT_IMPLIES(a_rd_in_walk, clk, rst, rd_valid, (state == ST_READ) || (state == ST_DRAIN))
  // the last cell read is always pending when draining
  `ASSERT_IMPLIES(a_drain_has_data, clk, rst, state == ST_DRAIN, rd_valid)
  // the row counter never runs past the bottom row
  `ASSERT_IMPLIES(a_row_bound, clk, rst, state == ST_READ, row_cnt <= row_end)
  // cells are written only by an accepted load
  `ASSERT_IMPLIES(a_write_on_load, clk, rst, mem_we, in_ready && !is_query)
  // a bad query result carries a zero sum
  `ASSERT_IMPLIES(a_bad_zero, clk, rst, out_valid && bad_query, sum == '0)
  // a finished result moves to the output register when the slot is free
  `ASSERT_NEXT(a_finish_out, clk, rst, (state == ST_FINISH) && out_free, out_valid)

endmodule
